// ===== sv/mi3_pkg.sv =====
// shared types and widths for the 3x3 matrix inverse
package mi3_pkg;

  localparam int ELEM_W    = 32;
  localparam int PROD_W    = 64;
  localparam int MIN_W     = 65;
  localparam int PART_W    = 65;
  localparam int DET_W     = 99;
  localparam int MAG_W     = 64;
  localparam int DEN_W     = 96;
  localparam int Q_W       = 32;
  localparam int LANES     = 9;
  localparam int FRONT_LAT = 6;
  localparam int LANE_LAT  = 34;

  localparam logic [Q_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef struct packed {
    logic signed [ELEM_W-1:0] m11;
    logic signed [ELEM_W-1:0] m12;
    logic signed [ELEM_W-1:0] m13;
    logic signed [ELEM_W-1:0] m21;
    logic signed [ELEM_W-1:0] m22;
    logic signed [ELEM_W-1:0] m23;
    logic signed [ELEM_W-1:0] m31;
    logic signed [ELEM_W-1:0] m32;
    logic signed [ELEM_W-1:0] m33;
  } mi3_in_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] r11;
    logic signed [ELEM_W-1:0] r12;
    logic signed [ELEM_W-1:0] r13;
    logic signed [ELEM_W-1:0] r21;
    logic signed [ELEM_W-1:0] r22;
    logic signed [ELEM_W-1:0] r23;
    logic signed [ELEM_W-1:0] r31;
    logic signed [ELEM_W-1:0] r32;
    logic signed [ELEM_W-1:0] r33;
    logic                     singular;
  } mi3_out_t;

  // one adjugate element as magnitude plus sign of the quotient
  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
  } mi3_lane_t;

  typedef struct packed {
    logic [DEN_W-1:0] den;
    logic             sing;
  } mi3_det_t;

endpackage

// ===== sv/mi3_front.sv =====
// cofactors, determinant and magnitudes, six register stages
module mi3_front (
  input  logic                                clk,
  input  logic                                adv,
  input  mi3_pkg::mi3_in_t                    in_data,
  output mi3_pkg::mi3_lane_t [mi3_pkg::LANES-1:0] lane,
  output mi3_pkg::mi3_det_t                   det
);

  localparam int L = mi3_pkg::LANES;

  mi3_pkg::mi3_in_t m_r;
  logic signed [mi3_pkg::ELEM_W-1:0] xa [L];
  logic signed [mi3_pkg::ELEM_W-1:0] xb [L];
  logic signed [mi3_pkg::ELEM_W-1:0] ya [L];
  logic signed [mi3_pkg::ELEM_W-1:0] yb [L];
  logic signed [mi3_pkg::PROD_W-1:0] pa_r [L];
  logic signed [mi3_pkg::PROD_W-1:0] pb_r [L];
  logic signed [mi3_pkg::MIN_W-1:0]  min3_r [L];
  logic signed [mi3_pkg::MIN_W-1:0]  min4_r [L];
  logic signed [mi3_pkg::MIN_W-1:0]  min5_r [L];
  logic signed [mi3_pkg::ELEM_W-1:0] col2_r [3];
  logic signed [mi3_pkg::ELEM_W-1:0] col3_r [3];
  logic signed [mi3_pkg::PART_W-1:0] pl_r [3];
  logic signed [mi3_pkg::PART_W-1:0] ph_r [3];
  logic signed [mi3_pkg::DET_W-1:0]  det_r;
  logic signed [mi3_pkg::DET_W-1:0]  det_sum;
  logic signed [mi3_pkg::DET_W-1:0]  det_abs;
  mi3_pkg::mi3_lane_t [L-1:0]        lane_r;
  mi3_pkg::mi3_det_t                 det_out_r;

  // product pairs of each cofactor, already in adjugate (transposed) order
  always_comb begin
    xa[0] = m_r.m22; xb[0] = m_r.m33; ya[0] = m_r.m23; yb[0] = m_r.m32;
    xa[1] = m_r.m13; xb[1] = m_r.m32; ya[1] = m_r.m12; yb[1] = m_r.m33;
    xa[2] = m_r.m12; xb[2] = m_r.m23; ya[2] = m_r.m13; yb[2] = m_r.m22;
    xa[3] = m_r.m23; xb[3] = m_r.m31; ya[3] = m_r.m21; yb[3] = m_r.m33;
    xa[4] = m_r.m11; xb[4] = m_r.m33; ya[4] = m_r.m13; yb[4] = m_r.m31;
    xa[5] = m_r.m13; xb[5] = m_r.m21; ya[5] = m_r.m11; yb[5] = m_r.m23;
    xa[6] = m_r.m21; xb[6] = m_r.m32; ya[6] = m_r.m22; yb[6] = m_r.m31;
    xa[7] = m_r.m12; xb[7] = m_r.m31; ya[7] = m_r.m11; yb[7] = m_r.m32;
    xa[8] = m_r.m11; xb[8] = m_r.m22; ya[8] = m_r.m12; yb[8] = m_r.m21;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_r <= in_data;
      col2_r[0] <= m_r.m11;
      col2_r[1] <= m_r.m21;
      col2_r[2] <= m_r.m31;
      col3_r    <= col2_r;
    end
  end

  for (genvar k = 0; k < L; k++) begin : g_cof
    always_ff @(posedge clk) begin
      if (adv) begin
        pa_r[k]   <= mi3_pkg::PROD_W'(xa[k]) * mi3_pkg::PROD_W'(xb[k]);
        pb_r[k]   <= mi3_pkg::PROD_W'(ya[k]) * mi3_pkg::PROD_W'(yb[k]);
        min3_r[k] <= mi3_pkg::MIN_W'(pa_r[k]) - mi3_pkg::MIN_W'(pb_r[k]);
        min4_r[k] <= min3_r[k];
        min5_r[k] <= min4_r[k];
      end
    end
  end

  // det by expansion down column one; 32 x 65 split into two partials
  for (genvar j = 0; j < 3; j++) begin : g_part
    always_ff @(posedge clk) begin
      if (adv) begin
        pl_r[j] <= mi3_pkg::PART_W'(col3_r[j])
                 * mi3_pkg::PART_W'($signed({1'b0, min3_r[j][31:0]}));
        ph_r[j] <= mi3_pkg::PART_W'(col3_r[j])
                 * mi3_pkg::PART_W'($signed(min3_r[j][64:32]));
      end
    end
  end

  always_comb begin
    det_sum = '0;
    for (int j = 0; j < 3; j++) begin
      det_sum = det_sum + (mi3_pkg::DET_W'(ph_r[j]) <<< 32) + mi3_pkg::DET_W'(pl_r[j]);
    end
    det_abs = det_r[mi3_pkg::DET_W-1] ? -det_r : det_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      det_r          <= det_sum;
      det_out_r.den  <= det_abs[mi3_pkg::DEN_W-1:0];
      det_out_r.sing <= (det_r == '0);
    end
  end

  for (genvar k = 0; k < L; k++) begin : g_mag
    logic signed [mi3_pkg::MIN_W-1:0] mabs;
    assign mabs = min5_r[k][mi3_pkg::MIN_W-1] ? -min5_r[k] : min5_r[k];
    always_ff @(posedge clk) begin
      if (adv) begin
        lane_r[k].mag <= mabs[mi3_pkg::MAG_W-1:0];
        lane_r[k].neg <= min5_r[k][mi3_pkg::MIN_W-1] ^ det_r[mi3_pkg::DET_W-1];
      end
    end
  end

  assign lane = lane_r;
  assign det  = det_out_r;

endmodule

// ===== sv/mi3_div_lane.sv =====
// one lane: pipelined restoring divide of an adjugate element by the determinant
module mi3_div_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          adv,
  input  mi3_pkg::mi3_lane_t            lane,
  input  logic [mi3_pkg::DEN_W-1:0]     den,
  output logic [mi3_pkg::Q_W-1:0]       res
);

  localparam int QW = mi3_pkg::Q_W;
  localparam int DW = mi3_pkg::DEN_W;
  localparam int NW = mi3_pkg::MAG_W + 2 * FRAC_BITS;
  localparam int CW = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic [CW-1:0] rem_r [QW+1];
  logic [DW-1:0] den_r [QW+1];
  logic [QW-1:0] q_r   [QW+1];
  logic          neg_r [QW+1];
  logic          sat_r [QW+1];
  logic [CW-1:0] num;
  logic [CW-1:0] den_top;
  logic [QW-1:0] res_r;

  assign num     = {{(CW-NW){1'b0}}, lane.mag, {(2*FRAC_BITS){1'b0}}};
  assign den_top = {{(CW-DW){1'b0}}, den} << QW;

  // quotient reaching 2^32 always saturates
  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= num;
      den_r[0] <= den;
      q_r[0]   <= '0;
      neg_r[0] <= lane.neg;
      sat_r[0] <= (num >= den_top);
    end
  end

  for (genvar s = 1; s <= QW; s++) begin : g_step
    localparam int B = QW - s;
    logic [CW-1:0] dsh;
    logic          ge;
    assign dsh = {{(CW-DW){1'b0}}, den_r[s-1]} << B;
    assign ge  = (rem_r[s-1] >= dsh);
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[s] <= ge ? rem_r[s-1] - dsh : rem_r[s-1];
        den_r[s] <= den_r[s-1];
        q_r[s]   <= q_r[s-1] | (QW'(ge) << B);
        neg_r[s] <= neg_r[s-1];
        sat_r[s] <= sat_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (neg_r[QW]) begin
        res_r <= (sat_r[QW] || q_r[QW] > mi3_pkg::SAT_NEG) ? mi3_pkg::SAT_NEG : -q_r[QW];
      end else begin
        res_r <= (sat_r[QW] || q_r[QW] > mi3_pkg::SAT_POS) ? mi3_pkg::SAT_POS : q_r[QW];
      end
    end
  end

  assign res = res_r;

endmodule

// ===== sv/matrix_inverse_3x3_core.sv =====
// top level: 3x3 matrix inverse by adjugate over determinant, Q-format fixed point
//
// input channel: in_valid / in_stall / in_data carry one 3x3 matrix per beat
// output channel: out_valid / out_stall / out_data carry the inverse plus a
//   singular flag per beat; a zero determinant gives singular and all-zero
//   elements, an out-of-range element saturates to the 32-bit signed limits
// throughput: one matrix per cycle while the output is not stalled
// pipeline: 6 front-end stages for products, cofactors, determinant and
//   magnitudes, then 34 stages in each of nine divide lanes: an input
//   register, one step per quotient bit and a saturating output register
// stall: a stalled output beat holds, the whole pipeline freezes and in_stall
//   rises in the same cycle; bubbles do not collapse
// reset: synchronous, active low, empties the pipeline; no config registers
module matrix_inverse_3x3_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mi3_pkg::mi3_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output mi3_pkg::mi3_out_t out_data
);

  localparam int L   = mi3_pkg::LANES;
  localparam int TOT = mi3_pkg::FRONT_LAT + mi3_pkg::LANE_LAT;

  logic                               adv;
  logic [TOT-1:0]                     vld_r;
  logic [mi3_pkg::LANE_LAT-1:0]       sing_r;
  mi3_pkg::mi3_lane_t [L-1:0]         lane;
  mi3_pkg::mi3_det_t                  det;
  logic [L-1:0][mi3_pkg::Q_W-1:0]     res;
  logic [L-1:0][mi3_pkg::Q_W-1:0]     res_m;

  // pipeline moves unless a finished beat is held at the output
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[TOT-2:0], in_valid};
    end
  end

  // singular flag rides alongside the divide lanes
  always_ff @(posedge clk) begin
    if (adv) begin
      sing_r <= {sing_r[mi3_pkg::LANE_LAT-2:0], det.sing};
    end
  end

  mi3_front u_front (
    .clk     (clk),
    .adv     (adv),
    .in_data (in_data),
    .lane    (lane),
    .det     (det)
  );

  for (genvar k = 0; k < L; k++) begin : g_lane
    mi3_div_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk  (clk),
      .adv  (adv),
      .lane (lane[k]),
      .den  (det.den),
      .res  (res[k])
    );
    // merge: singular matrix forces every element to zero
    assign res_m[k] = sing_r[mi3_pkg::LANE_LAT-1] ? '0 : res[k];
  end

  assign out_valid         = vld_r[TOT-1];
  assign out_data.r11      = res_m[0];
  assign out_data.r12      = res_m[1];
  assign out_data.r13      = res_m[2];
  assign out_data.r21      = res_m[3];
  assign out_data.r22      = res_m[4];
  assign out_data.r23      = res_m[5];
  assign out_data.r31      = res_m[6];
  assign out_data.r32      = res_m[7];
  assign out_data.r33      = res_m[8];
  assign out_data.singular = sing_r[mi3_pkg::LANE_LAT-1];

`ifndef SYNTHESIS
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.singular) |->
      (out_data.r11 == '0 && out_data.r12 == '0 && out_data.r13 == '0 &&
       out_data.r21 == '0 && out_data.r22 == '0 && out_data.r23 == '0 &&
       out_data.r31 == '0 && out_data.r32 == '0 && out_data.r33 == '0))
    else $error("singular beat with nonzero elements");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output beat right after reset");
`endif

endmodule

// ===== test/matrix_inverse_3x3_core_test.sv =====
// self-checking testbench for the 3x3 fixed-point matrix inverse core
module matrix_inverse_3x3_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int NUM_RANDOM = 400;
  // pipeline is 40 deep; allow long stalls on top
  localparam int DRAIN_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 5000;
  // window of cycles after reset with no random idling
  localparam int QUIET_START = 150;
  localparam int QUIET_END = 350;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  mi3_pkg::mi3_in_t in_data;
  logic out_valid;
  logic out_stall;
  mi3_pkg::mi3_out_t out_data;

  mi3_pkg::mi3_in_t pending_mats[$];
  mi3_pkg::mi3_out_t expected_inverses[$];
  int mismatch_count;
  int watchdog;
  int cycle_count;
  bit quiet_stretch;
  bit stim_done;

  matrix_inverse_3x3_core #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one quotient: (cof * 2^2F) / det, truncated toward zero, then clamped
  function automatic logic signed [31:0] divide_sat(logic signed [127:0] cof,
                                                    logic signed [127:0] det);
    logic [127:0] num_mag;
    logic [127:0] den_mag;
    logic [127:0] quo;
    bit neg;
    neg = (cof < 0) != (det < 0);
    num_mag = (cof < 0) ? -cof : cof;
    den_mag = (det < 0) ? -det : det;
    quo = (num_mag << (2 * FRAC)) / den_mag;
    if (!neg) begin
      if (quo > 128'h7FFF_FFFF) return mi3_pkg::SAT_POS;
      return quo[31:0];
    end
    if (quo > 128'h8000_0000) return mi3_pkg::SAT_NEG;
    return -quo[31:0];
  endfunction

  function automatic mi3_pkg::mi3_out_t invert_matrix(mi3_pkg::mi3_in_t m);
    logic signed [127:0] a11, a12, a13, a21, a22, a23, a31, a32, a33;
    logic signed [127:0] det;
    logic signed [127:0] cof [9];
    mi3_pkg::mi3_out_t r;
    a11 = m.m11; a12 = m.m12; a13 = m.m13;
    a21 = m.m21; a22 = m.m22; a23 = m.m23;
    a31 = m.m31; a32 = m.m32; a33 = m.m33;
    det = a11 * a22 * a33 + a12 * a23 * a31 + a13 * a21 * a32
        - a11 * a23 * a32 - a12 * a21 * a33 - a13 * a22 * a31;
    r = '0;
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    // adjugate: transposed cofactors
    cof[0] = a22 * a33 - a23 * a32;
    cof[1] = a13 * a32 - a12 * a33;
    cof[2] = a12 * a23 - a13 * a22;
    cof[3] = a23 * a31 - a21 * a33;
    cof[4] = a11 * a33 - a13 * a31;
    cof[5] = a13 * a21 - a11 * a23;
    cof[6] = a21 * a32 - a22 * a31;
    cof[7] = a12 * a31 - a11 * a32;
    cof[8] = a11 * a22 - a12 * a21;
    r.r11 = divide_sat(cof[0], det);
    r.r12 = divide_sat(cof[1], det);
    r.r13 = divide_sat(cof[2], det);
    r.r21 = divide_sat(cof[3], det);
    r.r22 = divide_sat(cof[4], det);
    r.r23 = divide_sat(cof[5], det);
    r.r31 = divide_sat(cof[6], det);
    r.r32 = divide_sat(cof[7], det);
    r.r33 = divide_sat(cof[8], det);
    return r;
  endfunction

  // random element: mostly moderate values, sometimes full range or extremes
  function automatic logic [31:0] rand_elem();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
    if (pick < 7) return $urandom;
    if (pick == 7) return 32'h8000_0000;
    if (pick == 8) return 32'h7FFF_FFFF;
    return $urandom_range(0, 3) - 1;
  endfunction

  function automatic mi3_pkg::mi3_in_t make_mat(logic [31:0] e [9]);
    mi3_pkg::mi3_in_t m;
    m.m11 = e[0]; m.m12 = e[1]; m.m13 = e[2];
    m.m21 = e[3]; m.m22 = e[4]; m.m23 = e[5];
    m.m31 = e[6]; m.m32 = e[7]; m.m33 = e[8];
    return m;
  endfunction

  // stimulus: directed cases, then random matrices
  initial begin
    logic [31:0] e [9];
    int kind;
    int i;
    rst_n = 1'b0;
    // identity
    e = '{32'h1_0000, 0, 0, 0, 32'h1_0000, 0, 0, 0, 32'h1_0000};
    pending_mats.push_back(make_mat(e));
    // all zero: singular
    e = '{default: 0};
    pending_mats.push_back(make_mat(e));
    // repeated rows: singular with nonzero cofactors
    e = '{32'h2_0000, 32'h3_0000, 32'h1_0000, 32'h2_0000, 32'h3_0000, 32'h1_0000,
          32'h5_0000, 32'hFFFF_0000, 32'h7_0000};
    pending_mats.push_back(make_mat(e));
    // tiny diagonal: inverse saturates positive
    e = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
    pending_mats.push_back(make_mat(e));
    // tiny diagonal with one negative entry: r11 saturates negative
    e = '{32'hFFFF_FFFF, 0, 0, 0, 1, 0, 0, 0, 1};
    pending_mats.push_back(make_mat(e));
    // most negative and most positive elements: all entries, diagonals and a mix
    e = '{default: 32'h8000_0000};
    pending_mats.push_back(make_mat(e));
    e = '{32'h8000_0000, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 32'h8000_0000};
    pending_mats.push_back(make_mat(e));
    e = '{32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF};
    pending_mats.push_back(make_mat(e));
    e = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1, 32'h7FFF_FFFF, 0,
          32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA};
    pending_mats.push_back(make_mat(e));
    // scaled permutation with a negative entry
    e = '{0, 32'hFFFF_0000, 0, 0, 0, 32'h2_0000, 32'h4_0000, 0, 0};
    pending_mats.push_back(make_mat(e));
    // exact inverse element of -2.0: m11 is half of -1 unit
    e = '{32'hFFFF_8000, 0, 0, 0, 32'h1_0000, 0, 0, 0, 32'h1_0000};
    pending_mats.push_back(make_mat(e));
    for (i = 0; i < NUM_RANDOM; i++) begin
      foreach (e[k]) e[k] = rand_elem();
      kind = $urandom_range(0, 9);
      // some rank-deficient matrices so singular shows up in random traffic
      if (kind == 0) begin
        e[6] = e[0]; e[7] = e[1]; e[8] = e[2];
      end else if (kind == 1) begin
        e[0] = 0; e[3] = 0; e[6] = 0;
      end
      pending_mats.push_back(make_mat(e));
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // fixed stretch of cycles with no random idling on either side
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycle_count <= 0;
      quiet_stretch <= 1'b0;
    end else begin
      cycle_count <= cycle_count + 1;
      quiet_stretch <= (cycle_count >= QUIET_START) && (cycle_count < QUIET_END);
    end
  end

  // driver: a beat is held until accepted
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      stim_done <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) expected_inverses.push_back(invert_matrix(in_data));
      if (pending_mats.size() > 0 && (quiet_stretch || $urandom_range(0, 99) >= 31)) begin
        in_valid <= 1'b1;
        in_data <= pending_mats.pop_front();
      end else begin
        in_valid <= 1'b0;
        if (pending_mats.size() == 0) stim_done <= 1'b1;
      end
    end
  end

  // receiver stall and output checking
  always_ff @(posedge clk) begin
    mi3_pkg::mi3_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      mismatch_count <= 0;
    end else begin
      out_stall <= !quiet_stretch && $urandom_range(0, 99) < 31;
      if (out_valid && !out_stall) begin
        if (expected_inverses.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10) $display("unexpected beat %h", out_data);
        end else begin
          want = expected_inverses.pop_front();
          if (want !== out_data) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
              $display("inverse mismatch: expected %h got %h", want, out_data);
          end
        end
      end
    end
  end

  // watchdog: cycles with no beat accepted on either channel
  always_ff @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      watchdog <= 0;
    end else begin
      watchdog <= watchdog + 1;
    end
  end

  // end of run
  initial begin
    @(posedge rst_n);
    while (!(stim_done && !in_valid && expected_inverses.size() == 0)
           && watchdog < WATCHDOG_LIMIT)
      @(posedge clk);
    if (watchdog >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk);
      if (mismatch_count == 0) begin
        $display("Testbench completed without errors");
      end else begin
        $display("Testbench completed WITH ERRORS");
      end
    end
    $finish;
  end

endmodule
